### hdl/sha1bs_pkg.sv
// Shared constants, command/status types and helper functions for the SHA-1 byte hash core.
`timescale 1ns / 1ps

package sha1bs_pkg;

  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int BLOCK_BYTES  = 64;
  localparam int BLOCK_BITS   = BLOCK_BYTES * BYTE_W;
  localparam int FILL_W       = 6;
  localparam int LEN_W        = 64;
  localparam int LEN_BYTES    = LEN_W / BYTE_W;
  localparam int LEN_OFFSET   = BLOCK_BYTES - LEN_BYTES;
  localparam int NUM_ROUNDS   = 80;
  localparam int ROUND_W      = 7;
  localparam int DIGEST_WORDS = 5;
  localparam int IDX_W        = 3;
  localparam int OUT_DATA_W   = 40;

  // padding byte selects
  localparam logic [1:0] PAD_MARK = 2'd0;
  localparam logic [1:0] PAD_ZERO = 2'd1;
  localparam logic [1:0] PAD_LEN  = 2'd2;

  localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;

  typedef struct packed {
    logic       load_byte;
    logic       pad_byte;
    logic [1:0] pad_sel;
    logic       work_load;
    logic       round_en;
    logic       chain_add;
    logic       publish;
    logic       clear;
  } sha1bs_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              ovf;
    logic              round_last;
    logic              out_busy;
  } sha1bs_sts_t;

  function automatic logic [WORD_W-1:0] init_word(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hEFCDAB89;
      3'd2:    w = 32'h98BADCFE;
      3'd3:    w = 32'h10325476;
      default: w = 32'hC3D2E1F0;
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
    logic [WORD_W-1:0] k;
    if (rnd < ROUND_W'(20)) begin
      k = 32'h5A827999;
    end else if (rnd < ROUND_W'(40)) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < ROUND_W'(60)) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

### hdl/sha1bs_datapath.sv
// Datapath: block shift buffer, message schedule, round unit, chaining state and output buffer.
`timescale 1ns / 1ps

module sha1bs_datapath
  import sha1bs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1bs_cmd_t           cmd,
  output sha1bs_sts_t           sts,
  input  logic [BYTE_W-1:0]     in_byte,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  logic [BLOCK_BITS-1:0]  blk_r, blk_nxt;
  logic [FILL_W-1:0]      fill_r;
  logic [LEN_W-1:0]       len_r, len_sum;
  logic                   ovf_r;
  logic [ROUND_W-1:0]     rnd_r;
  logic [WORD_W-1:0]      a_r, b_r, c_r, d_r, e_r;
  logic [WORD_W-1:0]      chain_r [DIGEST_WORDS];
  logic [WORD_W-1:0]      obuf_r  [DIGEST_WORDS];
  logic [IDX_W-1:0]       oidx_r;
  logic                   ostat_r;
  logic                   ovalid_r;

  logic                   shift_en;
  logic [BYTE_W-1:0]      pad_val, byte_val;
  logic [WORD_W-1:0]      w0, w2, w8, w13, w_mix, w_new;
  logic [WORD_W-1:0]      f_val, t_val;

  assign shift_en = (cmd.load_byte && !ovf_r) || cmd.pad_byte;
  assign len_sum  = len_r + LEN_W'(BYTE_W);

  always_comb begin
    case (cmd.pad_sel)
      PAD_MARK: pad_val = PAD_MARK_BYTE;
      // length bytes go out most significant first
      PAD_LEN:  pad_val = len_r[{~fill_r[2:0], 3'b000} +: BYTE_W];
      default:  pad_val = '0;
    endcase
  end

  assign byte_val = cmd.load_byte ? in_byte : pad_val;

  // schedule word j sits at the top of the buffer, word 0 highest
  assign w0    = blk_r[BLOCK_BITS-1            -: WORD_W];
  assign w2    = blk_r[BLOCK_BITS-1-2*WORD_W   -: WORD_W];
  assign w8    = blk_r[BLOCK_BITS-1-8*WORD_W   -: WORD_W];
  assign w13   = blk_r[BLOCK_BITS-1-13*WORD_W  -: WORD_W];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

  always_comb begin
    blk_nxt = blk_r;
    if (shift_en) begin
      blk_nxt = {blk_r[BLOCK_BITS-BYTE_W-1:0], byte_val};
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[BLOCK_BITS-WORD_W-1:0], w_new};
    end
  end

  always_comb begin
    if (rnd_r < ROUND_W'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
    end else if (rnd_r < ROUND_W'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
    end else if (rnd_r < ROUND_W'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    end else begin
      f_val = b_r ^ c_r ^ d_r;
    end
  end

  assign t_val = {a_r[WORD_W-6:0], a_r[WORD_W-1:WORD_W-5]} + f_val + e_r + w0 + round_k(rnd_r);

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (cmd.work_load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[WORD_W-1:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.publish) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        obuf_r[i] <= ovf_r ? '0 : chain_r[i];
      end
      ostat_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      fill_r <= '0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= init_word(IDX_W'(i));
      end
    end else begin
      if (shift_en) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.load_byte && !ovf_r) begin
        len_r <= len_sum;
        if (len_sum == '0) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (cmd.work_load) begin
      rnd_r <= '0;
    end else if (cmd.round_en) begin
      rnd_r <= rnd_r + 1'b1;
    end
  end

  // output buffer lets the core start the next message while words drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      oidx_r   <= '0;
    end else if (cmd.publish) begin
      ovalid_r <= 1'b1;
      oidx_r   <= '0;
    end else if (ovalid_r && out_tready) begin
      if (oidx_r == IDX_W'(DIGEST_WORDS-1)) begin
        ovalid_r <= 1'b0;
      end else begin
        oidx_r <= oidx_r + 1'b1;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_DATA_W-WORD_W-IDX_W){1'b0}}, oidx_r, obuf_r[oidx_r]};
  assign out_tlast  = (oidx_r == IDX_W'(DIGEST_WORDS-1));
  assign out_tuser  = ostat_r;

  assign sts.fill       = fill_r;
  assign sts.ovf        = ovf_r;
  assign sts.round_last = (rnd_r == ROUND_W'(NUM_ROUNDS-1));
  assign sts.out_busy   = ovalid_r;

endmodule

### hdl/sha1bs_ctrl.sv
// Controller: sequences absorb, padding, block compression and digest hand-off.
`timescale 1ns / 1ps

module sha1bs_ctrl
  import sha1bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  sha1bs_sts_t sts,
  output sha1bs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_PAD    = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_PUB    = 3'd6;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES-1);
  localparam logic [FILL_W-1:0] FILL_LEN  = FILL_W'(LEN_OFFSET);

  logic [2:0] state_r, state_nxt;
  logic       eom_r, eom_nxt;
  logic       mark_r, mark_nxt;
  logic       lenok_r, lenok_nxt;
  logic       final_r, final_nxt;
  logic [1:0] sel;

  always_comb begin
    state_nxt = state_r;
    eom_nxt   = eom_r;
    mark_nxt  = mark_r;
    lenok_nxt = lenok_r;
    final_nxt = final_r;
    cmd       = '0;
    in_tready = 1'b0;
    sel       = PAD_ZERO;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_byte = in_tuser;
          eom_nxt       = in_tlast;
          if (in_tuser && !sts.ovf && sts.fill == FILL_LAST) begin
            state_nxt = S_LOAD;
          end else if (in_tlast) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        state_nxt = sts.ovf ? S_PUB : S_PAD;
      end
      S_PAD: begin
        if (!mark_r) begin
          sel = PAD_MARK;
        end else if (lenok_r && sts.fill >= FILL_LEN) begin
          sel = PAD_LEN;
        end
        cmd.pad_byte = 1'b1;
        cmd.pad_sel  = sel;
        mark_nxt     = 1'b1;
        // marker leaves room for the length in this block
        if (!mark_r && sts.fill < FILL_LEN) begin
          lenok_nxt = 1'b1;
        end
        if (sts.fill == FILL_LAST) begin
          final_nxt = (sel == PAD_LEN);
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.work_load = 1'b1;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts.round_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (final_r) begin
          state_nxt = S_PUB;
        end else if (mark_r) begin
          lenok_nxt = 1'b1;
          state_nxt = S_PAD;
        end else if (eom_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PUB: begin
        // hold until the previous digest has drained
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          cmd.clear   = 1'b1;
          eom_nxt     = 1'b0;
          mark_nxt    = 1'b0;
          lenok_nxt   = 1'b0;
          final_nxt   = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      eom_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenok_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eom_r   <= eom_nxt;
      mark_r  <= mark_nxt;
      lenok_r <= lenok_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

### hdl/sha1_byte_stream_hash_core.sv
// Input: bytes are taken only in the idle state; after each full 64-byte block none is taken
// during the load, 80 rounds and chain add, as the single round unit does one round per cycle.
// End of message: a decision state, the padding bytes (up to 64, or up to 72 with an extra
// block), the compression(s), then the digest hand-off to the output buffer; on a length
// overflow the padding and compression are skipped. Output: five words leave at one per cycle
// while out_tready is high. Reset: rst_n synchronous, active low; returns chaining state,
// length and counters to start.
`timescale 1ns / 1ps

module sha1_byte_stream_hash_core
  import sha1bs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] byte_value
  input  logic                  in_tuser,   // [0] byte_valid
  input  logic                  in_tlast,   // end_of_message
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest 0
  output logic                  out_tuser,  // [0] status
  output logic                  out_tlast   // last_word
);

  sha1bs_cmd_t cmd;
  sha1bs_sts_t sts;

  sha1bs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha1bs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_no_input_during_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.round_en)
    else $error("input ready while compressing");

  a_publish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !sts.out_busy)
    else $error("digest published over an undrained one");

  a_error_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[WORD_W-1:0] == '0))
    else $error("nonzero word with error status");

  a_last_on_final_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[WORD_W+IDX_W-1:WORD_W] == IDX_W'(DIGEST_WORDS-1))))
    else $error("last flag does not match final word index");

  a_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> (sts.fill == '0 && !sts.ovf && out_tvalid))
    else $error("state not cleared after digest hand-off");

endmodule
